// File: rtl/core/sine_generator_with_sweep_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the sine generator core modules.
// Each macro expects signals named clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef SINE_GENERATOR_WITH_SWEEP_CORE_ASSERT_SVH
`define SINE_GENERATOR_WITH_SWEEP_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SGS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgs same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgs next-cycle check failed");

`endif

// File: rtl/core/sgs_pkg.sv
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared constants, the sine table and the divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sgs_pkg;

	// Default parameter values for the top level.
	localparam int DEF_SINE_POINTS     = 64;
	localparam int DEF_AVERAGE_COUNT   = 10;
	localparam int DEF_SAMPLE_INTERVAL = 10;
	localparam int DEF_CLOCK_HZ        = 16000000;
	localparam int DEF_TIMER_PRESCALE  = 64;

	// Request codes.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAMPLE = 2'd1;
	localparam logic [1:0] OP_BUTTON = 2'd2;

	// Field widths.
	localparam int OP_W    = 2;
	localparam int ADC_W   = 12;
	localparam int DAC_W   = 10;
	localparam int PER_W   = 9;
	localparam int FREQ_W  = 9;
	localparam int SUM_W   = 16;
	localparam int SWEEP_W = 14;
	localparam int MAG_W   = 9;
	localparam int POS_W   = 6;

	// Shared datapath widths. Every dividend and divisor fits 27 bits over
	// the whole parameter range; every quotient needed fits 10 bits.
	localparam int OPND_W  = 27;
	localparam int QUO_W   = 10;
	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 19;

	localparam int TABLE_LEN = 64;

	localparam logic [FREQ_W-1:0]  MIN_FREQ   = 9'd10;
	localparam logic [PER_W-1:0]   MAX_PERIOD = 9'd511;
	localparam logic [FREQ_W-1:0]  MAX_FREQ   = 9'd511;
	localparam logic [DAC_W-1:0]   MID_CODE   = 10'd512;
	localparam logic [DAC_W-1:0]   MAX_CODE   = 10'd1023;
	localparam logic [OPND_W-1:0]  AMP_DIV    = 27'd40960;
	localparam logic [OPND_W-1:0]  SWEEP_MS   = 27'd1000;
	localparam logic [MUL_B_W-1:0] FREQ_MUL   = 19'd297;
	localparam logic [MUL_B_W-1:0] SWEEP_RATE = 19'd18;
	localparam logic [SWEEP_W-1:0] SWEEP_TOP  = 14'd5000;
	localparam logic [SWEEP_W-1:0] SWEEP_END  = 14'd11000;
	localparam logic [QUO_W-1:0]   SWEEP_PEAK = 10'd190;

	localparam logic [DAC_W-1:0] WAVE_TABLE [TABLE_LEN] = '{
		10'd512, 10'd562, 10'd612, 10'd660, 10'd707, 10'd752, 10'd794, 10'd833,
		10'd868, 10'd900, 10'd927, 10'd950, 10'd968, 10'd982, 10'd991, 10'd995,
		10'd995, 10'd991, 10'd982, 10'd968, 10'd950, 10'd927, 10'd900, 10'd868,
		10'd833, 10'd794, 10'd752, 10'd707, 10'd660, 10'd612, 10'd562, 10'd512,
		10'd461, 10'd411, 10'd363, 10'd316, 10'd271, 10'd229, 10'd190, 10'd155,
		10'd123, 10'd95,  10'd72,  10'd53,  10'd39,  10'd30,  10'd25,  10'd24,
		10'd28,  10'd37,  10'd50,  10'd68,  10'd90,  10'd116, 10'd146, 10'd180,
		10'd218, 10'd259, 10'd303, 10'd350, 10'd399, 10'd449, 10'd500, 10'd551
	};

	typedef struct packed {
		logic              start;
		logic [OPND_W-1:0] dividend;
		logic [OPND_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/sgs_div.sv
// ----------------------------------------------------------------------------
// sgs_div
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_generator_with_sweep_core_assert.svh"

module sgs_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sgs_pkg::div_req_t req,
	output sgs_pkg::div_rsp_t      rsp
);

	localparam int SH_W  = sgs_pkg::OPND_W + sgs_pkg::QUO_W - 1;
	localparam int CMP_W = sgs_pkg::OPND_W + sgs_pkg::QUO_W;
	localparam int CNT_W = $clog2(sgs_pkg::QUO_W + 1);

	logic [sgs_pkg::OPND_W-1:0] rem_q;
	logic [SH_W-1:0]            sh_q;
	logic [sgs_pkg::QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       ovf_q;
	logic                       fits;
	logic                       ovf_start;

	// The quotient overflows its width when the dividend reaches the
	// divisor shifted past the top quotient bit.
	assign ovf_start = CMP_W'(req.dividend) >= {req.divisor, sgs_pkg::QUO_W'(0)};
	assign fits      = SH_W'(rem_q) >= sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(sgs_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			sh_q  <= {req.divisor, (sgs_pkg::QUO_W - 1)'(0)};
			quo_q <= '0;
			ovf_q <= ovf_start;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - sh_q[sgs_pkg::OPND_W-1:0];
			end
			quo_q <= {quo_q[sgs_pkg::QUO_W-2:0], fits};
			sh_q  <= sh_q >> 1;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.ovf      = ovf_q;
	assign rsp.quotient = quo_q;

	`SGS_ASSERT_NEXT(a_start_busy, req.start, busy_q)
	`SGS_ASSERT_IMPL(a_done_after_busy, done_q, !busy_q && $past(busy_q))
	`SGS_ASSERT_IMPL(a_no_restart, busy_q, !req.start)

endmodule

`default_nettype wire

// File: rtl/core/sine_generator_with_sweep_core.sv
// ----------------------------------------------------------------------------
// sine_generator_with_sweep_core
// Table sine generator whose amplitude and frequency follow a block average
// of converter codes, with a 10-100-10 Hz frequency sweep mode. Each request
// is a tick (op 0, carries adc_code), a sample event (op 1) or a sweep button
// press (op 2); only a sample event returns a result: dac_code, timer_period
// and frequency. Ticks outside sweep mode, button presses and op 3 finish in
// the idle state. A sweep tick runs the sweep pass; a sample event runs the
// amplitude, frequency and period passes in fixed mode, and the amplitude and
// period passes in sweep mode, each through one registered multiplier and one
// shared divider that retires one quotient bit per cycle. in_ready is high
// only while the sequencer is idle; a finished result waits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sine_generator_with_sweep_core_assert.svh"

module sine_generator_with_sweep_core #(
	parameter int SINE_POINTS     = sgs_pkg::DEF_SINE_POINTS,
	parameter int AVERAGE_COUNT   = sgs_pkg::DEF_AVERAGE_COUNT,
	parameter int SAMPLE_INTERVAL = sgs_pkg::DEF_SAMPLE_INTERVAL,
	parameter int CLOCK_HZ        = sgs_pkg::DEF_CLOCK_HZ,
	parameter int TIMER_PRESCALE  = sgs_pkg::DEF_TIMER_PRESCALE
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [sgs_pkg::OP_W-1:0]    op,
	input  wire logic [sgs_pkg::ADC_W-1:0]   adc_code,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [sgs_pkg::DAC_W-1:0]        dac_code,
	output logic [sgs_pkg::PER_W-1:0]        timer_period,
	output logic [sgs_pkg::FREQ_W-1:0]       frequency
);

	// Tick, block and table position counters are sized from the parameters.
	localparam int TICK_W = $clog2(SAMPLE_INTERVAL + 1);
	localparam int BLK_W  = $clog2(AVERAGE_COUNT + 1);
	localparam int IDX_W  = $clog2(SINE_POINTS);
	localparam int REM_W  = $clog2(SINE_POINTS + sgs_pkg::TABLE_LEN);
	// Largest number of table positions crossed by one sample step.
	localparam int POS_STEPS = (SINE_POINTS - 1 + sgs_pkg::TABLE_LEN) / SINE_POINTS;
	localparam logic [sgs_pkg::MUL_B_W-1:0] PER_SCALE =
		sgs_pkg::MUL_B_W'(SINE_POINTS * TIMER_PRESCALE);
	localparam logic [sgs_pkg::OPND_W-1:0] CLOCK_CONST = sgs_pkg::OPND_W'(CLOCK_HZ);
	localparam int PROD_W = sgs_pkg::MUL_A_W + sgs_pkg::MUL_B_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} state_t;

	// Which quantity the current multiply and divide pass produces.
	typedef enum logic [1:0] {
		PH_SWEEP,
		PH_AMP,
		PH_FREQ,
		PH_PER
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [TICK_W-1:0]                tick_q;
	logic [BLK_W-1:0]                 block_q;
	logic [sgs_pkg::SUM_W-1:0]        running_q;
	logic [sgs_pkg::SUM_W-1:0]        average_q;
	logic                             sweep_on_q;
	logic [sgs_pkg::SWEEP_W-1:0]      sweep_time_q;
	logic [sgs_pkg::FREQ_W-1:0]       freq_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [sgs_pkg::POS_W-1:0]        pos_q;
	logic [REM_W-1:0]                 rem_q;

	logic [sgs_pkg::MAG_W-1:0]        mag_q;
	logic                             neg_q;
	logic [sgs_pkg::OPND_W-1:0]       prod_q;
	logic [sgs_pkg::DAC_W-1:0]        dac_q;
	logic [sgs_pkg::PER_W-1:0]        per_q;

	logic                             out_valid_q;
	logic [sgs_pkg::DAC_W-1:0]        dac_out_q;
	logic [sgs_pkg::PER_W-1:0]        per_out_q;
	logic [sgs_pkg::FREQ_W-1:0]       freq_out_q;

	logic                             accept;
	logic [sgs_pkg::SUM_W-1:0]        running_n;
	logic [BLK_W-1:0]                 block_n;
	logic [sgs_pkg::SWEEP_W-1:0]      sweep_time_n;
	logic [REM_W-1:0]                 rem_n;
	logic [sgs_pkg::POS_W-1:0]        pos_step;
	logic [sgs_pkg::DAC_W-1:0]        entry;
	logic [sgs_pkg::MUL_A_W-1:0]      mul_a;
	logic [sgs_pkg::MUL_B_W-1:0]      mul_b;
	logic [PROD_W-1:0]                mul_full;
	logic [sgs_pkg::QUO_W-1:0]        quo;
	logic [sgs_pkg::QUO_W:0]          pos_sum;
	logic [sgs_pkg::QUO_W:0]          freq_sum;
	logic [sgs_pkg::QUO_W-1:0]        sweep_f;

	sgs_pkg::div_req_t div_req;
	sgs_pkg::div_rsp_t div_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign running_n    = running_q + sgs_pkg::SUM_W'(adc_code);
	assign block_n      = block_q + BLK_W'(1);
	assign sweep_time_n = sweep_time_q + sgs_pkg::SWEEP_W'(1);
	assign entry        = sgs_pkg::WAVE_TABLE[pos_q];

	// Table position tracks floor(index * table length / SINE_POINTS) with a
	// remainder, so a step adds the table length and folds out whole points.
	always_comb begin
		rem_n    = rem_q + REM_W'(sgs_pkg::TABLE_LEN);
		pos_step = '0;
		for (int k = 0; k < POS_STEPS; k++) begin
			if (rem_n >= REM_W'(SINE_POINTS)) begin
				rem_n    = rem_n - REM_W'(SINE_POINTS);
				pos_step = pos_step + sgs_pkg::POS_W'(1);
			end
		end
	end

	// Operand selection for the shared multiplier and divider.
	always_comb begin
		div_req.start = (state_q == ST_DIV);
		case (phase_q)
			PH_SWEEP: begin
				mul_a            = sgs_pkg::MUL_A_W'(sweep_time_q);
				mul_b            = sgs_pkg::SWEEP_RATE;
				div_req.dividend = prod_q;
				div_req.divisor  = sgs_pkg::SWEEP_MS;
			end
			PH_AMP: begin
				mul_a            = sgs_pkg::MUL_A_W'(mag_q);
				mul_b            = sgs_pkg::MUL_B_W'(average_q);
				div_req.dividend = prod_q;
				div_req.divisor  = sgs_pkg::AMP_DIV;
			end
			PH_FREQ: begin
				mul_a            = average_q;
				mul_b            = sgs_pkg::FREQ_MUL;
				div_req.dividend = prod_q;
				div_req.divisor  = sgs_pkg::AMP_DIV;
			end
			PH_PER: begin
				mul_a            = sgs_pkg::MUL_A_W'(freq_q);
				mul_b            = PER_SCALE;
				div_req.dividend = CLOCK_CONST;
				div_req.divisor  = prod_q;
			end
			default: begin
				mul_a            = '0;
				mul_b            = '0;
				div_req.dividend = '0;
				div_req.divisor  = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// Result shaping after each divide pass.
	assign quo      = div_rsp.quotient;
	assign pos_sum  = (sgs_pkg::QUO_W + 1)'(sgs_pkg::MID_CODE) + (sgs_pkg::QUO_W + 1)'(quo);
	assign freq_sum = (sgs_pkg::QUO_W + 1)'(sgs_pkg::MIN_FREQ) + (sgs_pkg::QUO_W + 1)'(quo);

	// Sweep frequency: rising half adds the step to the floor, falling half
	// subtracts it from the peak and stops at the floor.
	always_comb begin
		if (sweep_time_q < sgs_pkg::SWEEP_TOP) begin
			sweep_f = sgs_pkg::QUO_W'(sgs_pkg::MIN_FREQ) + quo;
		end else if (quo > sgs_pkg::SWEEP_PEAK - sgs_pkg::QUO_W'(sgs_pkg::MIN_FREQ)) begin
			sweep_f = sgs_pkg::QUO_W'(sgs_pkg::MIN_FREQ);
		end else begin
			sweep_f = sgs_pkg::SWEEP_PEAK - quo;
		end
	end

	sgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_SWEEP;
			tick_q       <= '0;
			block_q      <= '0;
			running_q    <= '0;
			average_q    <= '0;
			sweep_on_q   <= 1'b0;
			sweep_time_q <= '0;
			freq_q       <= sgs_pkg::MIN_FREQ;
			idx_q        <= '0;
			pos_q        <= '0;
			rem_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							sgs_pkg::OP_TICK: begin
								if (tick_q < TICK_W'(SAMPLE_INTERVAL)) begin
									tick_q <= tick_q + TICK_W'(1);
								end else begin
									tick_q <= '0;
									if (block_n >= BLK_W'(AVERAGE_COUNT)) begin
										average_q <= running_n;
										running_q <= '0;
										block_q   <= '0;
									end else begin
										running_q <= running_n;
										block_q   <= block_n;
									end
								end
								if (sweep_on_q) begin
									sweep_time_q <= sweep_time_n;
									phase_q      <= PH_SWEEP;
									state_q      <= ST_MUL;
								end
							end
							sgs_pkg::OP_SAMPLE: begin
								if (idx_q == IDX_W'(SINE_POINTS - 1)) begin
									idx_q <= '0;
									pos_q <= '0;
									rem_q <= '0;
								end else begin
									idx_q <= idx_q + IDX_W'(1);
									pos_q <= pos_q + pos_step;
									rem_q <= rem_n;
								end
								phase_q <= PH_AMP;
								state_q <= ST_MUL;
							end
							sgs_pkg::OP_BUTTON: begin
								sweep_on_q <= !sweep_on_q;
								freq_q     <= sgs_pkg::MIN_FREQ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_rsp.done) begin
						case (phase_q)
							PH_SWEEP: begin
								// At 11 s the sweep starts over from the floor.
								if (sweep_time_q >= sgs_pkg::SWEEP_END) begin
									sweep_time_q <= '0;
									freq_q       <= sgs_pkg::MIN_FREQ;
								end else begin
									freq_q <= sweep_f[sgs_pkg::FREQ_W-1:0];
								end
								state_q <= ST_IDLE;
							end
							PH_AMP: begin
								phase_q <= sweep_on_q ? PH_PER : PH_FREQ;
								state_q <= ST_MUL;
							end
							PH_FREQ: begin
								if (freq_sum > (sgs_pkg::QUO_W + 1)'(sgs_pkg::MAX_FREQ)) begin
									freq_q <= sgs_pkg::MAX_FREQ;
								end else begin
									freq_q <= freq_sum[sgs_pkg::FREQ_W-1:0];
								end
								phase_q <= PH_PER;
								state_q <= ST_MUL;
							end
							PH_PER: begin
								state_q <= ST_OUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		if (accept && op == sgs_pkg::OP_SAMPLE) begin
			if (entry >= sgs_pkg::MID_CODE) begin
				mag_q <= sgs_pkg::MAG_W'(entry - sgs_pkg::MID_CODE);
				neg_q <= 1'b0;
			end else begin
				mag_q <= sgs_pkg::MAG_W'(sgs_pkg::MID_CODE - entry);
				neg_q <= 1'b1;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_full[sgs_pkg::OPND_W-1:0];
		end
		if (state_q == ST_WAIT && div_rsp.done && phase_q == PH_AMP) begin
			// Amplitude scaling around mid-scale, clamped to the converter range.
			if (neg_q) begin
				dac_q <= (quo >= sgs_pkg::MID_CODE) ? '0 : sgs_pkg::MID_CODE - quo;
			end else if (pos_sum > (sgs_pkg::QUO_W + 1)'(sgs_pkg::MAX_CODE)) begin
				dac_q <= sgs_pkg::MAX_CODE;
			end else begin
				dac_q <= pos_sum[sgs_pkg::DAC_W-1:0];
			end
		end
		if (state_q == ST_WAIT && div_rsp.done && phase_q == PH_PER) begin
			if (div_rsp.ovf || quo > sgs_pkg::QUO_W'(sgs_pkg::MAX_PERIOD)) begin
				per_q <= sgs_pkg::MAX_PERIOD;
			end else begin
				per_q <= quo[sgs_pkg::PER_W-1:0];
			end
		end
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			dac_out_q  <= dac_q;
			per_out_q  <= per_q;
			freq_out_q <= freq_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign dac_code     = dac_out_q;
	assign timer_period = per_out_q;
	assign frequency    = freq_out_q;

	`SGS_ASSERT_IMPL(a_freq_floor, 1'b1, freq_q >= sgs_pkg::MIN_FREQ)
	`SGS_ASSERT_IMPL(a_sweep_in_range, state_q == ST_IDLE, sweep_time_q < sgs_pkg::SWEEP_END)
	`SGS_ASSERT_IMPL(a_done_while_wait, div_rsp.done, state_q == ST_WAIT)
	`SGS_ASSERT_IMPL(a_pos_rem_range, 1'b1, rem_q < REM_W'(SINE_POINTS))

endmodule

`default_nettype wire
